>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the lexer checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/jlex_pkg.sv
// ---------------------------------------------------------------------------
// jlex_pkg
// Types, codes and small helper functions shared by the JSON lexer files.
// ---------------------------------------------------------------------------
package jlex_pkg;

    // Field widths of the stream items
    localparam int CODE_W  = 21;
    localparam int KIND_W  = 2;
    localparam int TOKEN_W = 4;
    localparam int CMD_W   = 2;

    // Input commands
    localparam logic [CMD_W-1:0] CMD_CHAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_END   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TOKEN = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd3;

    // Token types
    localparam logic [TOKEN_W-1:0] TOK_BARR    = 4'd0;
    localparam logic [TOKEN_W-1:0] TOK_EARR    = 4'd1;
    localparam logic [TOKEN_W-1:0] TOK_BOBJ    = 4'd2;
    localparam logic [TOKEN_W-1:0] TOK_EOBJ    = 4'd3;
    localparam logic [TOKEN_W-1:0] TOK_NAMESEP = 4'd4;
    localparam logic [TOKEN_W-1:0] TOK_VALSEP  = 4'd5;
    localparam logic [TOKEN_W-1:0] TOK_STRING  = 4'd6;
    localparam logic [TOKEN_W-1:0] TOK_NUMBER  = 4'd7;
    localparam logic [TOKEN_W-1:0] TOK_TRUE    = 4'd8;
    localparam logic [TOKEN_W-1:0] TOK_FALSE   = 4'd9;
    localparam logic [TOKEN_W-1:0] TOK_NULL    = 4'd10;

    // Character codes
    localparam logic [CODE_W-1:0] CH_TAB    = 21'h09;
    localparam logic [CODE_W-1:0] CH_LF     = 21'h0A;
    localparam logic [CODE_W-1:0] CH_CR     = 21'h0D;
    localparam logic [CODE_W-1:0] CH_SPACE  = 21'h20;
    localparam logic [CODE_W-1:0] CH_QUOTE  = 21'h22;
    localparam logic [CODE_W-1:0] CH_PLUS   = 21'h2B;
    localparam logic [CODE_W-1:0] CH_COMMA  = 21'h2C;
    localparam logic [CODE_W-1:0] CH_MINUS  = 21'h2D;
    localparam logic [CODE_W-1:0] CH_DOT    = 21'h2E;
    localparam logic [CODE_W-1:0] CH_SLASH  = 21'h2F;
    localparam logic [CODE_W-1:0] CH_0      = 21'h30;
    localparam logic [CODE_W-1:0] CH_1      = 21'h31;
    localparam logic [CODE_W-1:0] CH_9      = 21'h39;
    localparam logic [CODE_W-1:0] CH_COLON  = 21'h3A;
    localparam logic [CODE_W-1:0] CH_UP_A   = 21'h41;
    localparam logic [CODE_W-1:0] CH_UP_E   = 21'h45;
    localparam logic [CODE_W-1:0] CH_UP_F   = 21'h46;
    localparam logic [CODE_W-1:0] CH_LBRACK = 21'h5B;
    localparam logic [CODE_W-1:0] CH_BSLASH = 21'h5C;
    localparam logic [CODE_W-1:0] CH_RBRACK = 21'h5D;
    localparam logic [CODE_W-1:0] CH_A      = 21'h61;
    localparam logic [CODE_W-1:0] CH_B      = 21'h62;
    localparam logic [CODE_W-1:0] CH_E      = 21'h65;
    localparam logic [CODE_W-1:0] CH_F      = 21'h66;
    localparam logic [CODE_W-1:0] CH_L      = 21'h6C;
    localparam logic [CODE_W-1:0] CH_N      = 21'h6E;
    localparam logic [CODE_W-1:0] CH_R      = 21'h72;
    localparam logic [CODE_W-1:0] CH_S      = 21'h73;
    localparam logic [CODE_W-1:0] CH_T      = 21'h74;
    localparam logic [CODE_W-1:0] CH_U      = 21'h75;
    localparam logic [CODE_W-1:0] CH_LBRACE = 21'h7B;
    localparam logic [CODE_W-1:0] CH_RBRACE = 21'h7D;

    // Decoded escape values
    localparam logic [CODE_W-1:0] CH_BS     = 21'h08;
    localparam logic [CODE_W-1:0] CH_FF     = 21'h0C;

    // Lexer states, one-hot
    typedef enum logic [25:0] {
        ST_IDLE    = 26'd1 << 0,
        ST_STR     = 26'd1 << 1,
        ST_ESC     = 26'd1 << 2,
        ST_U0      = 26'd1 << 3,
        ST_U1      = 26'd1 << 4,
        ST_U2      = 26'd1 << 5,
        ST_U3      = 26'd1 << 6,
        ST_F       = 26'd1 << 7,
        ST_FA      = 26'd1 << 8,
        ST_FAL     = 26'd1 << 9,
        ST_FALS    = 26'd1 << 10,
        ST_N       = 26'd1 << 11,
        ST_NU      = 26'd1 << 12,
        ST_NUL     = 26'd1 << 13,
        ST_T       = 26'd1 << 14,
        ST_TR      = 26'd1 << 15,
        ST_TRU     = 26'd1 << 16,
        ST_MINUS   = 26'd1 << 17,
        ST_ZERO    = 26'd1 << 18,
        ST_INT     = 26'd1 << 19,
        ST_DOT     = 26'd1 << 20,
        ST_FRAC    = 26'd1 << 21,
        ST_EXP     = 26'd1 << 22,
        ST_EXPSIGN = 26'd1 << 23,
        ST_EXPINT  = 26'd1 << 24,
        ST_ERR     = 26'd1 << 25
    } lex_state_t;

    // One result item
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [TOKEN_W-1:0] token_type;
        logic [CODE_W-1:0]  char_value;
    } res_t;

    // Results of one item, in order: first, then second
    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } step_t;

    // Outcome of lexing one character from idle
    typedef struct packed {
        logic       emit;
        res_t       res;
        lex_state_t next;
    } idle_t;

    function automatic res_t mk_res(logic [KIND_W-1:0] kind, logic [TOKEN_W-1:0] tt,
                                    logic [CODE_W-1:0] val);
        res_t r;
        r.kind       = kind;
        r.token_type = tt;
        r.char_value = val;
        return r;
    endfunction

    function automatic logic is_digit(logic [CODE_W-1:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    // Valid flag in the top bit, nibble below
    function automatic logic [4:0] hex_val(logic [CODE_W-1:0] c);
        logic [4:0] h;
        h = 5'd0;
        if (c >= CH_0 && c <= CH_9)
            h = {1'b1, 4'(c - CH_0)};
        else if (c >= CH_A && c <= CH_F)
            h = {1'b1, 4'(c - CH_A + 21'd10)};
        else if (c >= CH_UP_A && c <= CH_UP_F)
            h = {1'b1, 4'(c - CH_UP_A + 21'd10)};
        return h;
    endfunction

    function automatic idle_t lex_idle(logic [CODE_W-1:0] c);
        idle_t o;
        o.emit = 1'b1;
        o.next = ST_IDLE;
        o.res  = mk_res(KIND_CHAR, TOK_BARR, c);
        case (c)
            CH_TAB, CH_LF, CH_CR, CH_SPACE: o.emit = 1'b0;
            CH_QUOTE:
            begin
                o.emit = 1'b0;
                o.next = ST_STR;
            end
            CH_COMMA:  o.res = mk_res(KIND_TOKEN, TOK_VALSEP, '0);
            CH_COLON:  o.res = mk_res(KIND_TOKEN, TOK_NAMESEP, '0);
            CH_LBRACK: o.res = mk_res(KIND_TOKEN, TOK_BARR, '0);
            CH_RBRACK: o.res = mk_res(KIND_TOKEN, TOK_EARR, '0);
            CH_LBRACE: o.res = mk_res(KIND_TOKEN, TOK_BOBJ, '0);
            CH_RBRACE: o.res = mk_res(KIND_TOKEN, TOK_EOBJ, '0);
            CH_F:
            begin
                o.emit = 1'b0;
                o.next = ST_F;
            end
            CH_N:
            begin
                o.emit = 1'b0;
                o.next = ST_N;
            end
            CH_T:
            begin
                o.emit = 1'b0;
                o.next = ST_T;
            end
            CH_MINUS: o.next = ST_MINUS;
            CH_0:     o.next = ST_ZERO;
            default:
            begin
                if (c >= CH_1 && c <= CH_9)
                begin
                    o.next = ST_INT;
                end
                else
                begin
                    o.next = ST_ERR;
                    o.res  = mk_res(KIND_ERROR, TOK_BARR, '0);
                end
            end
        endcase
        return o;
    endfunction

endpackage

>>> rtl/jlex_step.sv
// ---------------------------------------------------------------------------
// jlex_step
// Lexer state register and the next-state / result logic for one item.
// ---------------------------------------------------------------------------
module jlex_step
    import jlex_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [CMD_W-1:0]  command,
    input  logic [CODE_W-1:0] char_code,
    output step_t             step
);

    lex_state_t  state_reg, state_next;
    logic [11:0] accum_reg, accum_next;

    res_t       err_res;
    idle_t      idle;
    logic [4:0] hex;

    assign err_res = mk_res(KIND_ERROR, TOK_BARR, '0);
    assign idle    = lex_idle(char_code);
    assign hex     = hex_val(char_code);

    // Work out the results and the next state of the current item
    always_comb
    begin
        state_next = state_reg;
        accum_next = accum_reg;
        step.count  = 2'd0;
        step.first  = '0;
        step.second = '0;

        case (command)
            CMD_CLEAR:
            begin
                state_next = ST_IDLE;
                accum_next = '0;
            end
            CMD_END:
            begin
                step.count = 2'd1;
                case (state_reg)
                    ST_IDLE: step.first = mk_res(KIND_END, TOK_BARR, '0);
                    ST_ZERO, ST_INT, ST_FRAC, ST_EXPINT:
                    begin
                        state_next  = ST_IDLE;
                        step.count  = 2'd2;
                        step.first  = mk_res(KIND_TOKEN, TOK_NUMBER, '0);
                        step.second = mk_res(KIND_END, TOK_BARR, '0);
                    end
                    default:
                    begin
                        state_next = ST_ERR;
                        step.first = err_res;
                    end
                endcase
            end
            CMD_CHAR:
            begin
                // Assume one payload character; arms below override
                step.count = 2'd1;
                step.first = mk_res(KIND_CHAR, TOK_BARR, char_code);
                case (state_reg)
                    ST_IDLE:
                    begin
                        state_next = idle.next;
                        step.count = {1'b0, idle.emit};
                        step.first = idle.res;
                    end
                    ST_STR:
                    begin
                        if (char_code == CH_QUOTE)
                        begin
                            state_next = ST_IDLE;
                            step.first = mk_res(KIND_TOKEN, TOK_STRING, '0);
                        end
                        else if (char_code == CH_BSLASH)
                        begin
                            state_next = ST_ESC;
                            step.count = 2'd0;
                        end
                    end
                    ST_ESC:
                    begin
                        state_next = ST_STR;
                        case (char_code)
                            CH_QUOTE, CH_SLASH, CH_BSLASH: ;
                            CH_B: step.first.char_value = CH_BS;
                            CH_F: step.first.char_value = CH_FF;
                            CH_R: step.first.char_value = CH_CR;
                            CH_N: step.first.char_value = CH_LF;
                            CH_T: step.first.char_value = CH_TAB;
                            CH_U:
                            begin
                                state_next = ST_U0;
                                accum_next = '0;
                                step.count = 2'd0;
                            end
                            default:
                            begin
                                state_next = ST_ERR;
                                step.first = err_res;
                            end
                        endcase
                    end
                    ST_U0, ST_U1, ST_U2, ST_U3:
                    begin
                        if (!hex[4])
                        begin
                            state_next = ST_ERR;
                            step.first = err_res;
                        end
                        else if (state_reg == ST_U3)
                        begin
                            state_next = ST_STR;
                            accum_next = '0;
                            step.first.char_value = CODE_W'({accum_reg, hex[3:0]});
                        end
                        else
                        begin
                            step.count = 2'd0;
                            accum_next = {accum_reg[7:0], hex[3:0]};
                            case (state_reg)
                                ST_U0:   state_next = ST_U1;
                                ST_U1:   state_next = ST_U2;
                                default: state_next = ST_U3;
                            endcase
                        end
                    end
                    ST_F, ST_FA, ST_FAL, ST_N, ST_NU, ST_T, ST_TR:
                    begin
                        // Middle letters of a literal: match and move on
                        step.count = 2'd0;
                        case (state_reg)
                            ST_F:
                            begin
                                if (char_code == CH_A) state_next = ST_FA;
                                else state_next = ST_ERR;
                            end
                            ST_FA:
                            begin
                                if (char_code == CH_L) state_next = ST_FAL;
                                else state_next = ST_ERR;
                            end
                            ST_FAL:
                            begin
                                if (char_code == CH_S) state_next = ST_FALS;
                                else state_next = ST_ERR;
                            end
                            ST_N:
                            begin
                                if (char_code == CH_U) state_next = ST_NU;
                                else state_next = ST_ERR;
                            end
                            ST_NU:
                            begin
                                if (char_code == CH_L) state_next = ST_NUL;
                                else state_next = ST_ERR;
                            end
                            ST_T:
                            begin
                                if (char_code == CH_R) state_next = ST_TR;
                                else state_next = ST_ERR;
                            end
                            default:
                            begin
                                if (char_code == CH_U) state_next = ST_TRU;
                                else state_next = ST_ERR;
                            end
                        endcase
                        if (state_next == ST_ERR)
                        begin
                            step.count = 2'd1;
                            step.first = err_res;
                        end
                    end
                    ST_FALS, ST_NUL, ST_TRU:
                    begin
                        // Final letter of a literal closes the token
                        if ((state_reg == ST_FALS && char_code == CH_E) ||
                            (state_reg == ST_NUL && char_code == CH_L) ||
                            (state_reg == ST_TRU && char_code == CH_E))
                        begin
                            state_next = ST_IDLE;
                            case (state_reg)
                                ST_FALS: step.first = mk_res(KIND_TOKEN, TOK_FALSE, '0);
                                ST_NUL:  step.first = mk_res(KIND_TOKEN, TOK_NULL, '0);
                                default: step.first = mk_res(KIND_TOKEN, TOK_TRUE, '0);
                            endcase
                        end
                        else
                        begin
                            state_next = ST_ERR;
                            step.first = err_res;
                        end
                    end
                    ST_MINUS:
                    begin
                        if (char_code == CH_0)
                            state_next = ST_ZERO;
                        else if (is_digit(char_code))
                            state_next = ST_INT;
                        else
                        begin
                            state_next = ST_ERR;
                            step.first = err_res;
                        end
                    end
                    ST_ZERO, ST_INT, ST_FRAC, ST_EXPINT:
                    begin
                        if (state_reg != ST_ZERO && is_digit(char_code))
                            state_next = state_reg;
                        else if (state_reg != ST_FRAC && state_reg != ST_EXPINT &&
                                 char_code == CH_DOT)
                            state_next = ST_DOT;
                        else if (state_reg != ST_EXPINT &&
                                 (char_code == CH_E || char_code == CH_UP_E))
                            state_next = ST_EXP;
                        else
                        begin
                            // Close the number, then lex this character from idle
                            state_next  = idle.next;
                            step.count  = idle.emit ? 2'd2 : 2'd1;
                            step.first  = mk_res(KIND_TOKEN, TOK_NUMBER, '0);
                            step.second = idle.res;
                        end
                    end
                    ST_DOT:
                    begin
                        if (is_digit(char_code))
                            state_next = ST_FRAC;
                        else
                        begin
                            state_next = ST_ERR;
                            step.first = err_res;
                        end
                    end
                    ST_EXP, ST_EXPSIGN:
                    begin
                        if (state_reg == ST_EXP &&
                            (char_code == CH_MINUS || char_code == CH_PLUS))
                            state_next = ST_EXPSIGN;
                        else if (is_digit(char_code))
                            state_next = ST_EXPINT;
                        else
                        begin
                            state_next = ST_ERR;
                            step.first = err_res;
                        end
                    end
                    default:
                    begin
                        // Sticky error: report and hold
                        state_next = ST_ERR;
                        step.first = err_res;
                    end
                endcase
            end
            default: ;
        endcase
    end

    // Commit the state once the item moves into the result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            accum_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
            accum_reg <= accum_next;
        end
    end

endmodule

>>> rtl/jlex_out.sv
// ---------------------------------------------------------------------------
// jlex_out
// Two-slot result register that hands the results of one item out in order.
// ---------------------------------------------------------------------------
module jlex_out
    import jlex_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  load,
    input  step_t step,
    input  logic  out_ready,
    output logic  out_valid,
    output res_t  out_res,
    output logic  out_last,
    output logic  free
);

    // Remaining results; a single result always sits in slot 1
    logic [1:0] cnt_reg, cnt_next;
    res_t       slot0_reg, slot0_next;
    res_t       slot1_reg, slot1_next;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_last  = (cnt_reg == 2'd1);
    assign out_res   = (cnt_reg == 2'd2) ? slot0_reg : slot1_reg;
    assign free      = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);

    // Load a new set of results or drain one
    always_comb
    begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (load)
        begin
            cnt_next = step.count;
            if (step.count == 2'd2)
            begin
                slot0_next = step.first;
                slot1_next = step.second;
            end
            else
            begin
                slot1_next = step.first;
            end
        end
        else if (out_valid && out_ready)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

>>> rtl/json_lexer.sv
// ---------------------------------------------------------------------------
// json_lexer
// Streaming JSON tokenizer, one character per item.
// ---------------------------------------------------------------------------
// Usage:
//   The slave channel takes one item per cycle while s_tready is high: a
//   command in s_tuser (character, end of input, clear) and a character
//   code in s_tdata. The master channel gives the results: payload
//   characters (string contents with escapes decoded, number text),
//   token-complete events with the token type, errors and end-accepted
//   marks. m_tlast flags the final result of an item; an item gives
//   zero, one or two results. An item passes the input register, then the
//   result register, before its first result is valid. Throughput: one
//   item per cycle while each item gives at most one result and the
//   receiver does not stall; an item with two results holds the result
//   register until both are taken, and the next item waits meanwhile.
//   When the receiver stalls, results hold on m_tdata and the input register
//   keeps one more item before s_tready drops.
//   Reset empties both registers and puts the lexer in its idle state with a
//   cleared escape value. Errors are sticky until a clear command.
// ---------------------------------------------------------------------------
module json_lexer
    import jlex_pkg::*;
#(
    parameter int CHAR_WIDTH = 21
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [20:0] char_code, [23:21] zero
    input  logic [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [3:0] token_type, [24:4] char_value, [31:25] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);

    localparam logic [CODE_W-1:0] CHAR_MASK = (CHAR_WIDTH >= CODE_W) ? {CODE_W{1'b1}} :
                                              CODE_W'((64'd1 << CHAR_WIDTH) - 64'd1);

    logic              in_valid_reg, in_valid_next;
    logic [CMD_W-1:0]  in_cmd_reg;
    logic [CODE_W-1:0] in_char_reg;
    logic              advance;
    logic              res_free;
    step_t             step;
    res_t              out_res;

    assign advance       = in_valid_reg && res_free;
    assign s_tready      = !in_valid_reg || advance;
    assign in_valid_next = (s_tvalid && s_tready) || (in_valid_reg && !advance);

    // Input register: take a new item whenever it is empty or the current one moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg  <= s_tuser;
            in_char_reg <= s_tdata[CODE_W-1:0] & CHAR_MASK;
        end
    end

    jlex_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .command   (in_cmd_reg),
        .char_code (in_char_reg),
        .step      (step)
    );

    jlex_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .step      (step),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_res   (out_res),
        .out_last  (m_tlast),
        .free      (res_free)
    );

    // Pack the result item
    assign m_tuser = out_res.kind;
    assign m_tdata = {7'd0, out_res.char_value, out_res.token_type};

endmodule

>>> rtl/jlex_checker.sv
// ---------------------------------------------------------------------------
// jlex_checker
// Port-level checks on the result stream of the JSON lexer.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module jlex_checker
    import jlex_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // Stalled result holds
    `ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

    // Errors and end marks always close an item
    `ASSERT_IMPLY(a_final, clk, rst_n, m_tvalid && (m_tuser == KIND_ERROR || m_tuser == KIND_END), m_tlast, "error or end result not last")

    // Only payload characters carry a character value
    `ASSERT_IMPLY(a_char_zero, clk, rst_n, m_tvalid && m_tuser != KIND_CHAR, m_tdata[24:4] == '0, "char value on non-payload result")

    // Token types stay in range and are zero outside token results
    `ASSERT_IMPLY(a_token, clk, rst_n, m_tvalid, (m_tuser == KIND_TOKEN) ? (m_tdata[3:0] <= TOK_NULL) : (m_tdata[3:0] == TOK_BARR), "bad token type")

endmodule

bind json_lexer jlex_checker u_jlex_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
